@@ rtl/weno5_pkg.sv @@
`default_nettype none
package weno5_pkg;

	// Payload width of the sample and face value fields.
	localparam int SMP_W = 32;
	localparam int DEFAULT_SAMPLE_WIDTH = 32;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam int EPS_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 1'd1;
	localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;

	// Back end arithmetic.
	localparam int UFRAC = 24;
	localparam int ACC_W = 64;
	localparam int DVD_W = ACC_W + UFRAC;
	localparam int STEPS_W = 7;
	localparam logic [STEPS_W-1:0] STEPS_INT = 7'd64;
	localparam logic [STEPS_W-1:0] STEPS_RATIO = 7'd88;
	// floor(v / 3) = (v * DIV3_RECIP) >> DIV3_SHIFT for v < 2^19
	localparam logic [19:0] DIV3_RECIP = 20'd349526;
	localparam int DIV3_SHIFT = 20;

	// Queue between front and back.
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic signed [SMP_W-1:0] f0;
		logic signed [SMP_W-1:0] f1;
		logic signed [SMP_W-1:0] f2;
		logic signed [SMP_W-1:0] f3;
		logic signed [SMP_W-1:0] f4;
	} stencil_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [ACC_W-1:0] divisor;
		logic [STEPS_W-1:0] steps;
	} div_req_t;

endpackage
`default_nettype wire

@@ rtl/weno5_ifs.sv @@
`default_nettype none
interface weno5_in_if;
	import weno5_pkg::*;
	logic valid;
	logic ready;
	logic signed [SMP_W-1:0] sample;
	logic first_of_line;
	modport source (output valid, output sample, output first_of_line, input ready);
	modport sink (input valid, input sample, input first_of_line, output ready);
endinterface

interface weno5_out_if;
	import weno5_pkg::*;
	logic valid;
	logic ready;
	logic signed [SMP_W-1:0] face_value;
	modport source (output valid, output face_value, input ready);
	modport sink (input valid, input face_value, output ready);
endinterface
`default_nettype wire

@@ rtl/weno5_face_reconstruction.sv @@
`default_nettype none
// WENO5 (Jiang-Shu, p = 2) face reconstruction over a stream of cell samples.
// Input channel in_ch: one beat per cell sample (signed Q16.16) plus a
// first_of_line flag that restarts the five-sample window. The first four
// beats of a line give no result; every later beat gives one face value on
// out_ch (signed Q16.16, saturated). cfg_we/cfg_index/cfg_wdata write the
// direction (index 0) and epsilon (index 1) registers; the user must write
// them only while idle, as the block itself does not enforce this. The front
// takes a beat every cycle while the two-entry stencil queue has room; the
// back works one stencil at a time on a shared 32x32 multiplier and a
// one-bit-per-cycle divider: three chunked divides by 12, three 88-step
// weight ratios and one 64-step final divide. The back pops the next
// stencil only after the current face value has moved into the output
// register. A finished value waits in the output register while out_ch
// stalls; the back then holds, the queue fills and in_ch.ready drops.
// Reset clears the window fill, queue, sequencer and output valid, and sets
// direction to 0 and epsilon to 4295 (about 1e-6).
module weno5_face_reconstruction #(
	parameter int SAMPLE_WIDTH = weno5_pkg::DEFAULT_SAMPLE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	weno5_in_if.sink                          in_ch,
	weno5_out_if.source                       out_ch,
	input  logic                              cfg_we,
	input  logic [weno5_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [weno5_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import weno5_pkg::*;

	// front to queue
	logic             q_push;
	logic             q_full;
	stencil_t         q_wdata;
	// queue to back
	logic             q_pop;
	logic             q_nonempty;
	stencil_t         q_rdata;
	logic [EPS_W-1:0] epsilon;

	// window and orientation; stalls only on a full queue
	weno5_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata),
		.epsilon   (epsilon)
	);

	weno5_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.nonempty (q_nonempty)
	);

	// arithmetic sequencer with the output register
	weno5_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_nonempty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.epsilon (epsilon),
		.out_ch  (out_ch)
	);

endmodule
`default_nettype wire

@@ rtl/weno5_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module weno5_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  weno5_pkg::div_req_t       req,
	output logic                      busy,
	output logic                      done,
	output logic [weno5_pkg::ACC_W-1:0] quo
);
	import weno5_pkg::*;

	logic [ACC_W-1:0]   rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [ACC_W-1:0]   dsr_q;
	logic [ACC_W-1:0]   quo_q;
	logic [STEPS_W-1:0] cnt_q;
	logic               done_q;

	logic [ACC_W:0] shifted;
	logic [ACC_W:0] diff;
	logic           ge;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEPS_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[ACC_W-1:0] : shifted[ACC_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[ACC_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/weno5_fifo.sv @@
`default_nettype none
// Short stencil queue between front and back.
module weno5_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  weno5_pkg::stencil_t wdata,
	output logic                full,
	input  logic                pop,
	output weno5_pkg::stencil_t rdata,
	output logic                nonempty
);
	import weno5_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	stencil_t           mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = cnt_q == CNT_W'(Q_DEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

@@ rtl/weno5_front.sv @@
`default_nettype none
// Front: config registers, sliding window, stencil orientation.
module weno5_front #(
	parameter int SAMPLE_WIDTH = weno5_pkg::DEFAULT_SAMPLE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	weno5_in_if.sink                          in_ch,
	input  logic                              cfg_we,
	input  logic [weno5_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [weno5_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              q_full,
	output logic                              q_push,
	output weno5_pkg::stencil_t               q_wdata,
	output logic [weno5_pkg::EPS_W-1:0]       epsilon
);
	import weno5_pkg::*;

	localparam int IW = (SAMPLE_WIDTH < SMP_W) ? SAMPLE_WIDTH : SMP_W;

	logic signed [IW-1:0] win_q [4];
	logic [2:0]           fill_q;
	logic                 direction_q;
	logic [EPS_W-1:0]     epsilon_q;

	logic                 accept;
	logic signed [IW-1:0] x;
	logic [2:0]           fill_eff;
	logic signed [SMP_W-1:0] xe, w0, w1, w2, w3;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign x           = in_ch.sample[IW-1:0];
	assign fill_eff    = in_ch.first_of_line ? 3'd0 : fill_q;
	assign q_push      = accept && (fill_eff == 3'd4);

	assign xe = SMP_W'(x);
	assign w0 = SMP_W'(win_q[0]);
	assign w1 = SMP_W'(win_q[1]);
	assign w2 = SMP_W'(win_q[2]);
	assign w3 = SMP_W'(win_q[3]);

	always_comb begin
		if (direction_q) begin
			q_wdata = '{f0: xe, f1: w3, f2: w2, f3: w1, f4: w0};
		end else begin
			q_wdata = '{f0: w0, f1: w1, f2: w2, f3: w3, f4: xe};
		end
	end

	assign epsilon = epsilon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			direction_q <= 1'b0;
			epsilon_q   <= EPS_RESET;
		end else begin
			if (accept) begin
				fill_q <= (fill_eff == 3'd4) ? 3'd4 : fill_eff + 3'd1;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIRECTION: direction_q <= cfg_wdata[0];
					CFG_EPSILON:   epsilon_q   <= cfg_wdata[EPS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// window contents are only read once four samples of the line are in
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= x;
		end
	end

endmodule
`default_nettype wire

@@ rtl/weno5_back.sv @@
`default_nettype none
// Back: WENO5 arithmetic sequencer with one shared multiplier and divider.
module weno5_back #(
	parameter int SAMPLE_WIDTH = weno5_pkg::DEFAULT_SAMPLE_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  weno5_pkg::stencil_t         q_rdata,
	output logic                        q_pop,
	input  logic [weno5_pkg::EPS_W-1:0] epsilon,
	weno5_out_if.source                 out_ch
);
	import weno5_pkg::*;

	localparam int IW = (SAMPLE_WIDTH < SMP_W) ? SAMPLE_WIDTH : SMP_W;
	localparam logic [ACC_W-1:0] SAT_HI = (64'd1 << (IW - 1)) - 64'd1;
	localparam logic [1:0] K_LAST = 2'd2;
	localparam logic [1:0] D3_LAST = 2'd3;

	typedef enum logic [3:0] {
		B_IDLE, B_SQA, B_SQB, B_IS, B_IS_WAIT, B_IS_SUM, B_MIN, B_RAT, B_RAT_WAIT,
		B_USQ, B_WLO, B_WHI, B_DEN, B_DEN_WAIT, B_OUT
	} state_t;

	state_t                 state_q;
	logic [1:0]             k_q;
	stencil_t               f_q;
	logic [ACC_W-1:0]       sqa_q, sqb_q, m_q;
	logic [ACC_W-1:0]       s_q [3];
	logic [UFRAC:0]         u_q;
	logic [35:0]            cmag_q;
	logic                   cneg_q;
	logic [27:0]            w_q;
	logic [27:0]            wsum_q;
	logic signed [ACC_W-1:0] num_q;
	logic [45:0]            part_q;
	logic [SMP_W-1:0]       res_q;
	logic                   ov_q;
	logic [SMP_W-1:0]       od_q;
	logic [ACC_W-1:0]       d3_y_q;
	logic [ACC_W-1:0]       d3_quo_q;
	logic [1:0]             d3_rem_q;
	logic [1:0]             d3_cnt_q;

	logic signed [35:0] fx0, fx1, fx2, fx3, fx4;
	logic signed [37:0] cx0, cx1, cx2, cx3, cx4;
	logic signed [35:0] a_k, b_k, sel_d;
	logic signed [37:0] cand;
	logic [35:0]        mag;
	logic [31:0]        ma, mb;
	logic [ACC_W-1:0]   prod, sq_val, t_sum, s_new, s_min, den, num_abs, q_sat;
	logic [27:0]        w_next;
	logic [ACC_W-1:0]   total;
	logic [SMP_W-1:0]   res_next;
	div_req_t           div_req;
	logic               div_busy, div_done;
	logic [ACC_W-1:0]   div_quo;
	logic [17:0]        d3_v;
	logic [37:0]        d3_p;
	logic [15:0]        d3_q;
	logic [17:0]        d3_r;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] x,
			input logic [ACC_W-1:0] y);
		logic [ACC_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[ACC_W] ? '1 : s[ACC_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] sat_mul13(input logic [ACC_W-1:0] x);
		logic [ACC_W+3:0] p;
		p = ({4'd0, x} << 3) + ({4'd0, x} << 2) + {4'd0, x};
		return (|p[ACC_W+3:ACC_W]) ? '1 : p[ACC_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] sat_mul3(input logic [ACC_W-1:0] x);
		logic [ACC_W+1:0] p;
		p = ({2'd0, x} << 1) + {2'd0, x};
		return (|p[ACC_W+1:ACC_W]) ? '1 : p[ACC_W-1:0];
	endfunction

	// linear weights 1, 6, 3
	function automatic logic [27:0] wgt(input logic [1:0] k, input logic [UFRAC:0] uu);
		logic [27:0] e;
		e = 28'(uu);
		case (k)
			2'd1:    return (e << 2) + (e << 1);
			2'd2:    return (e << 1) + e;
			default: return e;
		endcase
	endfunction

	assign fx0 = 36'(f_q.f0);
	assign fx1 = 36'(f_q.f1);
	assign fx2 = 36'(f_q.f2);
	assign fx3 = 36'(f_q.f3);
	assign fx4 = 36'(f_q.f4);
	assign cx0 = 38'(f_q.f0);
	assign cx1 = 38'(f_q.f1);
	assign cx2 = 38'(f_q.f2);
	assign cx3 = 38'(f_q.f3);
	assign cx4 = 38'(f_q.f4);

	// smoothness differences and candidates (six times value) of stencil k
	always_comb begin
		case (k_q)
			2'd0: begin
				a_k  = fx0 - (fx1 <<< 1) + fx2;
				b_k  = fx0 - (fx1 <<< 2) + (fx2 <<< 1) + fx2;
				cand = (cx0 <<< 1) - ((cx1 <<< 3) - cx1) + (cx2 <<< 3) + (cx2 <<< 1) + cx2;
			end
			2'd1: begin
				a_k  = fx1 - (fx2 <<< 1) + fx3;
				b_k  = fx1 - fx3;
				cand = -cx1 + (cx2 <<< 2) + cx2 + (cx3 <<< 1);
			end
			default: begin
				a_k  = fx2 - (fx3 <<< 1) + fx4;
				b_k  = (fx2 <<< 1) + fx2 - (fx3 <<< 2) + fx4;
				cand = (cx2 <<< 1) + (cx3 <<< 2) + cx3 - cx4;
			end
		endcase
	end

	assign sel_d = (state_q == B_SQA) ? a_k : b_k;
	assign mag   = sel_d[35] ? 36'(36'sd0 - sel_d) : 36'(sel_d);

	// single shared multiplier
	always_comb begin
		case (state_q)
			B_SQA, B_SQB: begin
				ma = mag[31:0];
				mb = mag[31:0];
			end
			B_USQ: begin
				ma = 32'(u_q);
				mb = 32'(u_q);
			end
			B_WLO: begin
				ma = 32'(w_q);
				mb = 32'(cmag_q[17:0]);
			end
			B_WHI: begin
				ma = 32'(w_q);
				mb = 32'(cmag_q[35:18]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod   = ma * mb;
	assign sq_val = (|mag[35:32]) ? '1 : prod;
	assign t_sum  = sat_add(sat_mul13(sqa_q), sat_mul3(sqb_q));
	assign w_next = wgt(k_q, prod[2*UFRAC:UFRAC]);
	assign total  = ACC_W'(part_q) + {prod[45:0], 18'd0};

	// divide by 12: drop two bits, then divide by 3 one 16-bit chunk per cycle,
	// MSB chunk first, carrying the remainder into the next chunk
	assign d3_v = {d3_rem_q, d3_y_q[ACC_W-1:ACC_W-16]};
	assign d3_p = 38'(d3_v) * 38'(DIV3_RECIP);
	assign d3_q = d3_p[DIV3_SHIFT+15:DIV3_SHIFT];
	assign d3_r = d3_v - ((18'(d3_q) << 1) + 18'(d3_q));

	always_comb begin
		s_new = sat_add(d3_quo_q, ACC_W'(epsilon));
		if (s_new == '0) begin
			s_new = ACC_W'(1);
		end
		s_min = s_q[0];
		if (s_q[1] < s_min) begin
			s_min = s_q[1];
		end
		if (s_q[2] < s_min) begin
			s_min = s_q[2];
		end
	end

	assign den     = (ACC_W'(wsum_q) << 2) + (ACC_W'(wsum_q) << 1);
	assign num_abs = num_q[ACC_W-1] ? ACC_W'(64'sd0 - num_q) : ACC_W'(num_q);

	// round-half-away quotient saturated to the sample range
	always_comb begin
		if (num_q[ACC_W-1]) begin
			q_sat    = (div_quo > SAT_HI + 64'd1) ? SAT_HI + 64'd1 : div_quo;
			res_next = SMP_W'(64'd0 - q_sat);
		end else begin
			q_sat    = (div_quo > SAT_HI) ? SAT_HI : div_quo;
			res_next = SMP_W'(q_sat);
		end
	end

	always_comb begin
		div_req = '{start: 1'b0, dividend: '0, divisor: '0, steps: '0};
		case (state_q)
			B_RAT: begin
				div_req = '{start: 1'b1, dividend: {m_q, {UFRAC{1'b0}}},
					divisor: s_q[k_q], steps: STEPS_RATIO};
			end
			B_DEN: begin
				div_req = '{start: 1'b1, dividend: {num_abs + (den >> 1), {UFRAC{1'b0}}},
					divisor: den, steps: STEPS_INT};
			end
			default: ;
		endcase
	end

	weno5_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign q_pop            = (state_q == B_IDLE) && q_valid;
	assign out_ch.valid      = ov_q;
	assign out_ch.face_value = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			k_q      <= '0;
			d3_cnt_q <= '0;
			ov_q     <= 1'b0;
			od_q     <= '0;
		end else begin
			if (ov_q && out_ch.ready && state_q != B_OUT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						k_q     <= '0;
						state_q <= B_SQA;
					end
				end
				B_SQA: state_q <= B_SQB;
				B_SQB: state_q <= B_IS;
				B_IS: begin
					d3_cnt_q <= '0;
					state_q  <= B_IS_WAIT;
				end
				B_IS_WAIT: begin
					d3_cnt_q <= d3_cnt_q + 2'd1;
					if (d3_cnt_q == D3_LAST) begin
						state_q <= B_IS_SUM;
					end
				end
				B_IS_SUM: begin
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= B_MIN;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= B_SQA;
					end
				end
				B_MIN: state_q <= B_RAT;
				B_RAT: state_q <= B_RAT_WAIT;
				B_RAT_WAIT: begin
					if (div_done) begin
						state_q <= B_USQ;
					end
				end
				B_USQ: state_q <= B_WLO;
				B_WLO: state_q <= B_WHI;
				B_WHI: begin
					if (k_q == K_LAST) begin
						state_q <= B_DEN;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= B_RAT;
					end
				end
				B_DEN: state_q <= B_DEN_WAIT;
				B_DEN_WAIT: begin
					if (div_done) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (!ov_q || out_ch.ready) begin
						ov_q    <= 1'b1;
						od_q    <= res_q;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					f_q    <= q_rdata;
					num_q  <= '0;
					wsum_q <= '0;
				end
			end
			B_SQA: sqa_q <= sq_val;
			B_SQB: sqb_q <= sq_val;
			B_IS: begin
				d3_y_q   <= t_sum >> 2;
				d3_rem_q <= '0;
			end
			B_IS_WAIT: begin
				d3_y_q   <= d3_y_q << 16;
				d3_rem_q <= d3_r[1:0];
				d3_quo_q <= {d3_quo_q[ACC_W-17:0], d3_q};
			end
			B_IS_SUM: s_q[k_q] <= s_new;
			B_MIN: m_q <= s_min;
			B_RAT_WAIT: begin
				if (div_done) begin
					u_q    <= div_quo[UFRAC:0];
					cneg_q <= cand[37];
					cmag_q <= cand[37] ? 36'(38'sd0 - cand) : 36'(cand);
				end
			end
			B_USQ: begin
				w_q    <= w_next;
				wsum_q <= wsum_q + w_next;
			end
			B_WLO: part_q <= prod[45:0];
			B_WHI: num_q <= cneg_q ? num_q - $signed(total) : num_q + $signed(total);
			B_DEN_WAIT: begin
				if (div_done) begin
					res_q <= res_next;
				end
			end
			default: ;
		endcase
	end

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DEN) |-> (wsum_q != '0))
		else $error("weight sum zero at final divide");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider restarted while busy");

	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RAT_WAIT && div_done) |-> (div_quo <= (64'd1 << UFRAC)))
		else $error("weight ratio above one");

endmodule
`default_nettype wire
